/* rtl/mtcp_pkg.sv */
// ----------------------------------------------------------------------------
// mtcp_pkg
// shared types and constants of the midi track chunk parser
// ----------------------------------------------------------------------------
package mtcp_pkg;

    localparam int DELTA_W  = 28;
    localparam int TDATA_W  = 112;
    localparam int TUSER_W  = 6;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // result kinds
    localparam logic [3:0] KIND_NOTEOFF   = 4'd0;
    localparam logic [3:0] KIND_META      = 4'd7;
    localparam logic [3:0] KIND_SYSEX     = 4'd8;
    localparam logic [3:0] KIND_HEADERERR = 4'd9;
    localparam logic [3:0] KIND_VLQERR    = 4'd10;

    // status bytes
    localparam logic [7:0] ST_META        = 8'hFF;
    localparam logic [7:0] ST_SYSEX       = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC   = 8'hF7;
    localparam logic [7:0] META_EOT       = 8'h2F;

    // chunk id "MTrk"
    localparam logic [7:0] TRACK_ID [4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};

    typedef struct packed {
        logic [3:0]         kind;
        logic [DELTA_W-1:0] delta_time;
        logic [3:0]         channel;
        logic [7:0]         first_value;
        logic [7:0]         second_value;
        logic [14:0]        bend_value;
        logic [7:0]         meta_type;
        logic [DELTA_W-1:0] payload_length;
        logic [7:0]         payload_byte;
        logic               payload_valid;
        logic               last_of_event;
        logic               end_of_track;
    } t_result;

endpackage

/* rtl/mtcp_front.sv */
// ----------------------------------------------------------------------------
// mtcp_front
// byte parser: header check, vlq decode, running status, event results
// ----------------------------------------------------------------------------
module mtcp_front #(
    parameter int VLQ_MAX_BYTES = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output mtcp_pkg::t_result o_res
);
    import mtcp_pkg::*;

    localparam int VW = $clog2(VLQ_MAX_BYTES + 1);

    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_DELTA     = 3'd1;
    localparam logic [2:0] PH_STATUS    = 3'd2;
    localparam logic [2:0] PH_DATA1     = 3'd3;
    localparam logic [2:0] PH_DATA2     = 3'd4;
    localparam logic [2:0] PH_META_TYPE = 3'd5;
    localparam logic [2:0] PH_LENGTH    = 3'd6;
    localparam logic [2:0] PH_PAYLOAD   = 3'd7;

    logic [2:0]         r_phase,     n_phase;
    logic [2:0]         r_hcount,    n_hcount;
    logic               r_hok,       n_hok;
    logic [7:0]         r_kept,      n_kept;
    logic [7:0]         r_evst,      n_evst;
    logic [DELTA_W-1:0] r_delta,     n_delta;
    logic [VW-1:0]      r_vlq,       n_vlq;
    logic [7:0]         r_first,     n_first;
    logic [7:0]         r_mtype,     n_mtype;
    logic [DELTA_W-1:0] r_length,    n_length;
    logic [DELTA_W-1:0] r_left,      n_left;

    logic               vlq_full;
    logic [VW-1:0]      vlq_inc;
    logic [DELTA_W-1:0] delta_shift;
    logic [DELTA_W-1:0] length_shift;
    logic               is_meta;
    t_result            res;
    logic               res_valid;

    assign vlq_full     = (r_vlq >= VW'(VLQ_MAX_BYTES));
    assign vlq_inc      = VW'(r_vlq + VW'(1));
    assign delta_shift  = {r_delta[DELTA_W-8:0], i_byte[6:0]};
    assign length_shift = {r_length[DELTA_W-8:0], i_byte[6:0]};
    assign is_meta      = (r_evst == ST_META);

    always_comb begin
        n_phase  = r_phase;
        n_hcount = r_hcount;
        n_hok    = r_hok;
        n_kept   = r_kept;
        n_evst   = r_evst;
        n_delta  = r_delta;
        n_vlq    = r_vlq;
        n_first  = r_first;
        n_mtype  = r_mtype;
        n_length = r_length;
        n_left   = r_left;
        res       = '0;
        res_valid = 1'b0;

        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_hcount[2] == 1'b0 && i_byte != TRACK_ID[r_hcount[1:0]]) begin
                        n_hok = 1'b0;
                    end
                    if (r_hcount == 3'd7) begin
                        n_hcount = '0;
                        n_kept   = '0;
                        if (!r_hok) begin
                            res.kind          = KIND_HEADERERR;
                            res.last_of_event = 1'b1;
                            res_valid         = 1'b1;
                            n_hok             = 1'b1;
                        end else begin
                            n_phase = PH_DELTA;
                            n_delta = '0;
                            n_vlq   = '0;
                        end
                    end else begin
                        n_hcount = r_hcount + 3'd1;
                    end
                end
                PH_DELTA, PH_LENGTH: begin
                    if (vlq_full) begin
                        res.kind          = KIND_VLQERR;
                        res.last_of_event = 1'b1;
                        res_valid         = 1'b1;
                        n_phase           = PH_HEADER;
                        n_hcount          = '0;
                        n_hok             = 1'b1;
                        n_kept            = '0;
                    end else begin
                        n_vlq = vlq_inc;
                        if (r_phase == PH_DELTA) begin
                            n_delta = delta_shift;
                            if (!i_byte[7]) begin
                                n_phase = PH_STATUS;
                            end
                        end else begin
                            n_length = length_shift;
                            if (!i_byte[7]) begin
                                n_left = length_shift;
                                if (length_shift == '0) begin
                                    // empty payload: one marker result
                                    res.kind           = is_meta ? KIND_META : KIND_SYSEX;
                                    res.delta_time     = r_delta;
                                    res.meta_type      = is_meta ? r_mtype : 8'h00;
                                    res.last_of_event  = 1'b1;
                                    if (is_meta && r_mtype == META_EOT) begin
                                        res.end_of_track = 1'b1;
                                        n_phase  = PH_HEADER;
                                        n_hcount = '0;
                                        n_hok    = 1'b1;
                                        n_kept   = '0;
                                    end else begin
                                        n_phase = PH_DELTA;
                                        n_delta = '0;
                                        n_vlq   = '0;
                                    end
                                    res_valid = 1'b1;
                                end else begin
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                end
                PH_STATUS: begin
                    priority if (i_byte == ST_META) begin
                        n_evst  = i_byte;
                        n_kept  = '0;
                        n_phase = PH_META_TYPE;
                    end else if (i_byte == ST_SYSEX || i_byte == ST_SYSEX_ESC) begin
                        n_evst   = i_byte;
                        n_kept   = '0;
                        n_mtype  = '0;
                        n_length = '0;
                        n_vlq    = '0;
                        n_phase  = PH_LENGTH;
                    end else if (i_byte[7] && i_byte[7:4] != 4'hF) begin
                        n_kept  = i_byte;
                        n_evst  = i_byte;
                        n_phase = PH_DATA1;
                    end else if (!i_byte[7] && r_kept != '0) begin
                        // running status
                        n_evst  = r_kept;
                        n_first = i_byte;
                        if (r_kept[7:5] == 3'b110) begin
                            res.kind          = KIND_NOTEOFF | {1'b0, r_kept[6:4]};
                            res.delta_time    = r_delta;
                            res.channel       = r_kept[3:0];
                            res.first_value   = i_byte;
                            res.last_of_event = 1'b1;
                            res_valid         = 1'b1;
                            n_phase           = PH_DELTA;
                            n_delta           = '0;
                            n_vlq             = '0;
                        end else begin
                            n_phase = PH_DATA2;
                        end
                    end else begin
                        // unknown status or no running status: drop
                        n_phase = PH_DELTA;
                        n_delta = '0;
                        n_vlq   = '0;
                    end
                end
                PH_DATA1: begin
                    n_first = i_byte;
                    if (r_evst[7:5] == 3'b110) begin
                        res.kind          = KIND_NOTEOFF | {1'b0, r_evst[6:4]};
                        res.delta_time    = r_delta;
                        res.channel       = r_evst[3:0];
                        res.first_value   = i_byte;
                        res.last_of_event = 1'b1;
                        res_valid         = 1'b1;
                        n_phase           = PH_DELTA;
                        n_delta           = '0;
                        n_vlq             = '0;
                    end else begin
                        n_phase = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    res.kind          = KIND_NOTEOFF | {1'b0, r_evst[6:4]};
                    res.delta_time    = r_delta;
                    res.channel       = r_evst[3:0];
                    res.first_value   = r_first;
                    res.second_value  = i_byte;
                    if (r_evst[6:4] == 3'd6) begin
                        res.bend_value = 15'(r_first) | (15'(i_byte) << 7);
                    end
                    res.last_of_event = 1'b1;
                    res_valid         = 1'b1;
                    n_phase           = PH_DELTA;
                    n_delta           = '0;
                    n_vlq             = '0;
                end
                PH_META_TYPE: begin
                    n_mtype  = i_byte;
                    n_length = '0;
                    n_vlq    = '0;
                    n_phase  = PH_LENGTH;
                end
                PH_PAYLOAD: begin
                    n_left             = r_left - DELTA_W'(1);
                    res.kind           = is_meta ? KIND_META : KIND_SYSEX;
                    res.delta_time     = r_delta;
                    res.meta_type      = is_meta ? r_mtype : 8'h00;
                    res.payload_length = r_length;
                    res.payload_byte   = i_byte;
                    res.payload_valid  = 1'b1;
                    res_valid          = 1'b1;
                    if (r_left == DELTA_W'(1)) begin
                        res.last_of_event = 1'b1;
                        if (is_meta && r_mtype == META_EOT) begin
                            res.end_of_track = 1'b1;
                            n_phase  = PH_HEADER;
                            n_hcount = '0;
                            n_hok    = 1'b1;
                            n_kept   = '0;
                        end else begin
                            n_phase = PH_DELTA;
                            n_delta = '0;
                            n_vlq   = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hcount <= '0;
            r_hok    <= 1'b1;
            r_kept   <= '0;
            r_evst   <= '0;
            r_delta  <= '0;
            r_vlq    <= '0;
            r_first  <= '0;
            r_mtype  <= '0;
            r_length <= '0;
            r_left   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_hok    <= n_hok;
            r_kept   <= n_kept;
            r_evst   <= n_evst;
            r_delta  <= n_delta;
            r_vlq    <= n_vlq;
            r_first  <= n_first;
            r_mtype  <= n_mtype;
            r_length <= n_length;
            r_left   <= n_left;
        end
    end

    assign o_res_valid = res_valid;
    assign o_res       = res;

endmodule

/* rtl/mtcp_queue.sv */
// ----------------------------------------------------------------------------
// mtcp_queue
// short result queue between parser and output stage
// ----------------------------------------------------------------------------
module mtcp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtcp_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output mtcp_pkg::t_result o_data
);
    import mtcp_pkg::*;

    t_result           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? QPTR_W'(r_wr_ptr + QPTR_W'(1)) : r_wr_ptr;
        n_rd_ptr = do_pop  ? QPTR_W'(r_rd_ptr + QPTR_W'(1)) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = QCNT_W'(r_count + QCNT_W'(1));
        end else if (do_pop && !do_push) begin
            n_count = QCNT_W'(r_count - QCNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/mtcp_back.sv */
// ----------------------------------------------------------------------------
// mtcp_back
// output register: drains the queue and packs results onto the stream
// ----------------------------------------------------------------------------
module mtcp_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  mtcp_pkg::t_result            i_q_data,
    output logic                         o_q_pop,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [mtcp_pkg::TDATA_W-1:0] o_tdata,
    output logic [mtcp_pkg::TUSER_W-1:0] o_tuser,
    output logic                         o_tlast
);
    import mtcp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;
    logic    take;

    // register is free when empty or its transfer completes now
    assign take    = !r_valid || i_tready;
    assign o_q_pop = take && i_q_valid;
    assign n_valid = take ? i_q_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_res <= i_q_data;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tlast  = r_res.last_of_event;
    assign o_tuser  = {r_res.end_of_track, r_res.payload_valid, r_res.kind};
    assign o_tdata  = {5'b0, r_res.payload_byte, r_res.payload_length, r_res.meta_type,
                       r_res.bend_value, r_res.second_value, r_res.first_value,
                       r_res.channel, r_res.delta_time};

endmodule

/* rtl/midi_track_chunk_parser.sv */
// ----------------------------------------------------------------------------
// midi_track_chunk_parser
// standard midi file track chunk parser, one byte per transfer
// ----------------------------------------------------------------------------
// results go from the parser via the result queue and output register to
// the master side; throughput is one byte per cycle while the queue is not
// full, set by the parser step and a two-entry result queue ahead of the
// output register. reset (synchronous, active low) returns the parser to
// waiting for a chunk header and empties the queue and output register.
// ----------------------------------------------------------------------------
module midi_track_chunk_parser #(
    parameter int VLQ_MAX_BYTES = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [7:0]                   i_s_axis_tdata,  // data_byte
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // delta_time[27:0] channel[31:28] first_value[39:32] second_value[47:40]
    // bend_value[62:48] meta_type[70:63] payload_length[98:71]
    // payload_byte[106:99] zero[111:107]
    output logic [mtcp_pkg::TDATA_W-1:0] o_m_axis_tdata,
    // kind[3:0] payload_valid[4] end_of_track[5]
    output logic [mtcp_pkg::TUSER_W-1:0] o_m_axis_tuser,
    output logic                         o_m_axis_tlast   // last_of_event
);
    import mtcp_pkg::*;

    logic    in_xfer;
    logic    front_valid;
    t_result front_res;
    logic    q_full;
    logic    q_valid;
    t_result q_data;
    logic    q_pop;

    assign o_s_axis_tready = !q_full;
    assign in_xfer         = i_s_axis_tvalid && !q_full;

    mtcp_front #(
        .VLQ_MAX_BYTES (VLQ_MAX_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_xfer),
        .i_byte      (i_s_axis_tdata),
        .o_res_valid (front_valid),
        .o_res       (front_res)
    );

    mtcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_res),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    mtcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tuser   (o_m_axis_tuser),
        .o_tlast   (o_m_axis_tlast)
    );

endmodule

/* rtl/mtcp_checker.sv */
// ----------------------------------------------------------------------------
// mtcp_checker
// port-level checks of the track chunk parser
// ----------------------------------------------------------------------------
module mtcp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready,
    input logic [mtcp_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input logic [mtcp_pkg::TUSER_W-1:0] o_m_axis_tuser,
    input logic                         o_m_axis_tlast
);
    import mtcp_pkg::*;

    // reset empties the output stage
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // errors close their event and carry no delta time
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid &&
        (o_m_axis_tuser[3:0] == KIND_HEADERERR || o_m_axis_tuser[3:0] == KIND_VLQERR) |->
            o_m_axis_tlast && o_m_axis_tdata[27:0] == '0 && !o_m_axis_tuser[4])
        else $error("malformed error result");

    // end of track only on the last result of a meta 0x2f event
    a_eot_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[5] |->
            o_m_axis_tuser[3:0] == KIND_META && o_m_axis_tlast &&
            o_m_axis_tdata[70:63] == META_EOT)
        else $error("bad end of track marker");

    // payload bytes only come with meta or sysex results
    a_payload_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[4] |->
            o_m_axis_tuser[3:0] == KIND_META || o_m_axis_tuser[3:0] == KIND_SYSEX)
        else $error("payload byte on a non payload result");

endmodule

bind midi_track_chunk_parser mtcp_checker u_mtcp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

/* test/tb_midi_track_chunk_parser.sv */
// ----------------------------------------------------------------------------
// tb_midi_track_chunk_parser
// self-checking bench for the midi track chunk parser: a byte stream of
// whole tracks (good and broken headers, channel messages with and without
// running status, meta and sysex events, unknown status, empty running
// status, over-long delta and length fields) is pushed through the slave
// side; a cycle-free model of the parser predicts every master transfer,
// which is compared field by field in order
// ----------------------------------------------------------------------------
module tb_midi_track_chunk_parser;
    import mtcp_pkg::*;

    localparam int         VLQ_LIMIT   = 4;
    localparam int         NUM_BYTES   = 1350;
    localparam int         HOLD_CYCLES = 64;
    localparam logic [3:0] KIND_BEND   = 4'd6;
    // program change and channel pressure carry one data byte
    localparam logic [2:0] ONE_DATA_HI = 3'b110;

    typedef enum logic [2:0] {
        PH_HEADER, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2,
        PH_META_TYPE, PH_LENGTH, PH_PAYLOAD
    } t_phase;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                s_valid   = 1'b0;
    logic [7:0]          s_data    = 8'h00;
    logic                s_ready;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [TDATA_W-1:0]  m_data;
    logic [TUSER_W-1:0]  m_user;
    logic                m_last;

    logic [7:0] track_bytes [$];
    t_result    expected_results [$];
    int         bad_results  = 0;
    int         bytes_taken  = 0;
    int         send_idle    = 10;
    int         recv_idle    = 72;
    bit         hold_request = 1'b0;
    int         hold_left    = 0;
    int         drain_cycles;

    // parser state as seen by the predictor
    t_phase      phase;
    int          hdr_count;
    bit          hdr_ok;
    logic [7:0]  run_status;
    logic [7:0]  ev_status;
    logic [27:0] delta_acc;
    int          vlq_taken;
    logic [7:0]  held_data;
    logic [7:0]  held_type;
    logic [27:0] len_acc;
    logic [27:0] left_bytes;

    // stimulus generator keeps its own view of running status
    bit          gen_running;
    logic [7:0]  gen_status;

    midi_track_chunk_parser #(
        .VLQ_MAX_BYTES(VLQ_LIMIT)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .o_m_axis_tlast (m_last)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void restart_track();
        phase      = PH_HEADER;
        hdr_count  = 0;
        hdr_ok     = 1'b1;
        run_status = 8'h00;
    endfunction

    function automatic void start_delta();
        phase     = PH_DELTA;
        delta_acc = '0;
        vlq_taken = 0;
    endfunction

    function automatic void clear_parser();
        restart_track();
        ev_status  = 8'h00;
        delta_acc  = '0;
        vlq_taken  = 0;
        held_data  = 8'h00;
        held_type  = 8'h00;
        len_acc    = '0;
        left_bytes = '0;
    endfunction

    function automatic bit error_result(input logic [3:0] kind, output t_result r);
        r               = '0;
        r.kind          = kind;
        r.last_of_event = 1'b1;
        restart_track();
        return 1'b1;
    endfunction

    function automatic bit channel_result(input logic [7:0] second, output t_result r);
        r               = '0;
        r.kind          = {1'b0, ev_status[6:4]};
        r.delta_time    = delta_acc;
        r.channel       = ev_status[3:0];
        r.first_value   = held_data;
        r.second_value  = second;
        if (r.kind == KIND_BEND) begin
            r.bend_value = 15'(held_data) | (15'(second) << 7);
        end
        r.last_of_event = 1'b1;
        start_delta();
        return 1'b1;
    endfunction

    function automatic bit payload_result(input logic [7:0] b, input bit valid,
                                          input bit last, output t_result r);
        bit is_meta;
        is_meta          = (ev_status == ST_META);
        r                = '0;
        r.kind           = is_meta ? KIND_META : KIND_SYSEX;
        r.delta_time     = delta_acc;
        r.meta_type      = is_meta ? held_type : 8'h00;
        r.payload_length = len_acc;
        r.payload_byte   = valid ? b : 8'h00;
        r.payload_valid  = valid;
        r.last_of_event  = last;
        if (last) begin
            if (is_meta && held_type == META_EOT) begin
                r.end_of_track = 1'b1;
                restart_track();
            end else begin
                start_delta();
            end
        end
        return 1'b1;
    endfunction

    // one byte into the parser; returns 1 when it yields a result
    function automatic bit parse_track_byte(input logic [7:0] b, output t_result r);
        r = '0;
        case (phase)
            PH_HEADER: begin
                if (hdr_count < 4 && b != TRACK_ID[hdr_count[1:0]]) hdr_ok = 1'b0;
                if (hdr_count >= 7) begin
                    if (!hdr_ok) return error_result(KIND_HEADERERR, r);
                    run_status = 8'h00;
                    start_delta();
                    return 1'b0;
                end
                hdr_count++;
                return 1'b0;
            end
            PH_DELTA: begin
                if (vlq_taken >= VLQ_LIMIT) return error_result(KIND_VLQERR, r);
                delta_acc = {delta_acc[20:0], b[6:0]};
                vlq_taken++;
                if (!b[7]) phase = PH_STATUS;
                return 1'b0;
            end
            PH_STATUS: begin
                if (b == ST_META) begin
                    ev_status  = b;
                    run_status = 8'h00;
                    phase      = PH_META_TYPE;
                end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                    ev_status  = b;
                    run_status = 8'h00;
                    held_type  = 8'h00;
                    len_acc    = '0;
                    vlq_taken  = 0;
                    phase      = PH_LENGTH;
                end else if (b >= 8'h80 && b < 8'hF0) begin
                    run_status = b;
                    ev_status  = b;
                    phase      = PH_DATA1;
                end else if (b < 8'h80 && run_status != 8'h00) begin
                    ev_status = run_status;
                    held_data = b;
                    if (ev_status[7:5] == ONE_DATA_HI) return channel_result(8'h00, r);
                    phase = PH_DATA2;
                end else begin
                    // unknown status or nothing to run on: drop it
                    start_delta();
                end
                return 1'b0;
            end
            PH_DATA1: begin
                held_data = b;
                if (ev_status[7:5] == ONE_DATA_HI) return channel_result(8'h00, r);
                phase = PH_DATA2;
                return 1'b0;
            end
            PH_DATA2: return channel_result(b, r);
            PH_META_TYPE: begin
                held_type = b;
                len_acc   = '0;
                vlq_taken = 0;
                phase     = PH_LENGTH;
                return 1'b0;
            end
            PH_LENGTH: begin
                if (vlq_taken >= VLQ_LIMIT) return error_result(KIND_VLQERR, r);
                len_acc = {len_acc[20:0], b[6:0]};
                vlq_taken++;
                if (!b[7]) begin
                    left_bytes = len_acc;
                    if (left_bytes == '0) return payload_result(8'h00, 1'b0, 1'b1, r);
                    phase = PH_PAYLOAD;
                end
                return 1'b0;
            end
            PH_PAYLOAD: begin
                left_bytes = left_bytes - 28'd1;
                return payload_result(b, 1'b1, left_bytes == '0, r);
            end
            default: begin
                restart_track();
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    task automatic add_vlq(input int unsigned value, input int nbytes);
        int i;
        for (i = nbytes - 1; i >= 0; i--) begin
            track_bytes.push_back({i > 0, 7'(value >> (7 * i))});
        end
    endtask

    task automatic add_delta();
        int          nbytes;
        int unsigned value;
        nbytes = ($urandom_range(9) < 7) ? 1 : $urandom_range(2, 4);
        value  = $urandom & ((32'd1 << (7 * nbytes)) - 1);
        if ($urandom_range(19) == 0) begin
            nbytes = 4;
            value  = 32'h0FFF_FFFF;
        end
        add_vlq(value, nbytes);
    endtask

    // over-long field: four continued bytes and one that trips the limit
    task automatic add_long_vlq();
        int i;
        for (i = 0; i < VLQ_LIMIT; i++) track_bytes.push_back(8'h80 | 8'($urandom));
        track_bytes.push_back(8'($urandom));
    endtask

    task automatic add_blob(input logic [7:0] st, input logic [7:0] mtype, input int len);
        int i;
        track_bytes.push_back(st);
        if (st == ST_META) track_bytes.push_back(mtype);
        // short lengths, sometimes with a redundant leading group
        add_vlq(len, ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1);
        for (i = 0; i < len; i++) track_bytes.push_back(8'($urandom));
        gen_running = 1'b0;
    endtask

    task automatic add_channel();
        logic [7:0] st;
        add_delta();
        if (gen_running && $urandom_range(9) < 4) begin
            st = gen_status;
            track_bytes.push_back(8'($urandom_range(127)));
        end else begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            gen_status  = st;
            gen_running = 1'b1;
            track_bytes.push_back(st);
            track_bytes.push_back(8'($urandom));
        end
        if (st[7:5] != ONE_DATA_HI) track_bytes.push_back(8'($urandom));
    endtask

    task automatic add_track();
        logic [7:0] id [4];
        logic [7:0] mtype;
        logic [7:0] junk;
        int         i;
        int         pick;
        int         n_events;
        id = TRACK_ID;
        if ($urandom_range(11) == 0) begin
            pick             = $urandom_range(3);
            id[pick[1:0]]    = id[pick[1:0]] ^ 8'($urandom_range(1, 255));
        end
        for (i = 0; i < 4; i++) track_bytes.push_back(id[i]);
        for (i = 0; i < 4; i++) track_bytes.push_back(8'($urandom));
        if (id != TRACK_ID) return;
        gen_running = 1'b0;
        n_events    = $urandom_range(3, 20);
        for (i = 0; i < n_events; i++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                add_channel();
            end else if (pick < 60) begin
                add_delta();
                mtype = 8'($urandom);
                if (mtype == META_EOT) mtype = 8'h2E;
                add_blob(ST_META, mtype, $urandom_range(0, 5));
            end else if (pick < 72) begin
                add_delta();
                add_blob($urandom_range(1) ? ST_SYSEX : ST_SYSEX_ESC, 8'h00,
                         $urandom_range(0, 5));
            end else if (pick < 80) begin
                add_delta();
                junk = 8'($urandom_range(8'hF1, 8'hFE));
                if (junk == ST_SYSEX_ESC) junk = 8'hF8;
                track_bytes.push_back(junk);
            end else if (pick < 86) begin
                add_delta();
                // a bare data byte only drops when no running status is held
                if (gen_running) track_bytes.push_back(8'hF4);
                else track_bytes.push_back(8'($urandom_range(127)));
            end else if (pick < 89) begin
                add_long_vlq();
                return;
            end else if (pick < 92) begin
                add_delta();
                track_bytes.push_back($urandom_range(1) ? ST_META : ST_SYSEX);
                if (track_bytes[$] == ST_META) track_bytes.push_back(8'($urandom));
                add_long_vlq();
                return;
            end else begin
                add_channel();
            end
        end
        add_delta();
        add_blob(ST_META, META_EOT, ($urandom_range(4) == 0) ? $urandom_range(1, 2) : 0);
    endtask

    // ------------------------------------------------------------------
    // slave side driver
    // ------------------------------------------------------------------
    always @(posedge clk) begin : drive_bytes
        t_result res;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (parse_track_byte(s_data, res)) expected_results.push_back(res);
                bytes_taken++;
            end
            if (!s_valid || s_ready) begin
                if (track_bytes.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_valid <= 1'b1;
                    s_data  <= track_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // master side: ready pattern and result checker
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic check_field(input string name, input logic [27:0] want,
                               input logic [27:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            bad_results++;
        end
    endtask

    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no event pending");
                bad_results++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind",           28'(want.kind),       28'(m_user[3:0]));
                check_field("delta_time",     want.delta_time,      m_data[27:0]);
                check_field("channel",        28'(want.channel),    28'(m_data[31:28]));
                check_field("first_value",    28'(want.first_value), 28'(m_data[39:32]));
                check_field("second_value",   28'(want.second_value),
                            28'(m_data[47:40]));
                check_field("bend_value",     28'(want.bend_value), 28'(m_data[62:48]));
                check_field("meta_type",      28'(want.meta_type),  28'(m_data[70:63]));
                check_field("payload_length", want.payload_length,  m_data[98:71]);
                check_field("payload_byte",   28'(want.payload_byte),
                            28'(m_data[106:99]));
                check_field("payload_valid",  28'(want.payload_valid), 28'(m_user[4]));
                check_field("last_of_event",  28'(want.last_of_event), 28'(m_last));
                check_field("end_of_track",   28'(want.end_of_track),  28'(m_user[5]));
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        clear_parser();
        gen_running = 1'b0;
        gen_status  = 8'h00;

        // header with all-ones length, max delta, bend with top-bit data,
        // bend again on running status with zero data, then end of track
        track_bytes = '{8'h4D, 8'h54, 8'h72, 8'h6B, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                        8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hEF, 8'hFF, 8'h80,
                        8'h00, 8'h00, 8'h00,
                        8'h00, ST_META, META_EOT, 8'h00};
        while (track_bytes.size() < NUM_BYTES) add_track();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_taken < NUM_BYTES / 3) @(posedge clk);
        send_idle = 72;
        recv_idle = 10;
        while (bytes_taken < 2 * NUM_BYTES / 3) @(posedge clk);
        send_idle    = 0;
        recv_idle    = 0;
        hold_request = 1'b1;

        while (track_bytes.size() > 0 || s_valid) @(posedge clk);
        drain_cycles = 0;
        while (expected_results.size() > 0 && drain_cycles < 5000) begin
            @(posedge clk);
            drain_cycles++;
        end
        if (expected_results.size() > 0) begin
            $error("%0d expected results never came out", expected_results.size());
            bad_results++;
        end
        repeat (20) @(posedge clk);
        if (bad_results == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
